>>> sv/brmf_pkg.sv
// Shared types and constants of the byte ring message FIFO.
`default_nettype none

package brmf_pkg;

    localparam int DATA_W             = 64;
    localparam int RING_DEPTH_DEF     = 256;
    localparam int MAX_ITEM_BYTES_DEF = 8;

    localparam int SIZE_W  = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 5;

    localparam logic [SIZE_W-1:0]  SIZE_RST  = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd31;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic CFG_ITEM_SIZE  = 1'b0;
    localparam logic CFG_ITEM_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

>>> sv/brmf_req_if.sv
// Request channel: push or pop with message bytes.
`default_nettype none

interface brmf_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [brmf_pkg::DATA_W-1:0] push_data;

    modport source (output valid, output action, output push_data, input ready);
    modport sink   (input valid, input action, input push_data, output ready);
endinterface

`default_nettype wire

>>> sv/brmf_rsp_if.sv
// Response channel: status, popped bytes and ring flags.
`default_nettype none

interface brmf_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [brmf_pkg::DATA_W-1:0] pop_data;
    logic                        now_full;
    logic                        now_empty;

    modport source (output valid, output status, output pop_data, output now_full,
                    output now_empty, input ready);
    modport sink   (input valid, input status, input pop_data, input now_full,
                    input now_empty, output ready);
endinterface

`default_nettype wire

>>> sv/byte_ring_message_fifo_top.sv
// Top level of the byte ring message FIFO: configuration, sequencer and ring.
//
//   channel   dir  modport  payload
//   i_req     in   sink     action, push_data
//   o_rsp     out  source   status, pop_data, now_full, now_empty
//   i_cfg_*   in   -        we, idx (0 item_size, 1 item_count), wdata
//
// A push passes WRITE then FIN, a pop READ, DRAIN then FIN, a refused request
// only FIN; WRITE and READ each move size bytes, size being the effective
// item size, one ring byte per cycle through the single write or read port.
// Reset empties the queue; ring bytes are not cleared and need no sweep.
// A finished response waits in the output register while the next request
// is taken; the sequencer stalls only when a second response is ready.
`default_nettype none

module byte_ring_message_fifo_top #(
    parameter int RING_DEPTH     = brmf_pkg::RING_DEPTH_DEF,
    parameter int MAX_ITEM_BYTES = brmf_pkg::MAX_ITEM_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    brmf_req_if.sink                        i_req,
    brmf_rsp_if.source                      o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [brmf_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(RING_DEPTH + 1);

    logic [brmf_pkg::SIZE_W-1:0]  r_item_size;
    logic [brmf_pkg::COUNT_W-1:0] r_item_count;
    logic [brmf_pkg::SIZE_W-1:0]  eff_size;
    logic [brmf_pkg::COUNT_W-1:0] eff_count;
    logic [LW-1:0]                ring_len;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_size  <= brmf_pkg::SIZE_RST;
            r_item_count <= brmf_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                brmf_pkg::CFG_ITEM_SIZE:  r_item_size  <= i_cfg_wdata[brmf_pkg::SIZE_W-1:0];
                brmf_pkg::CFG_ITEM_COUNT: r_item_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp size and count, then the ring length to the memory depth.
    always_comb begin
        logic [8:0] prod;
        logic [9:0] total;
        eff_size = r_item_size;
        if (r_item_size == '0) begin
            eff_size = brmf_pkg::SIZE_W'(1);
        end else if (r_item_size > brmf_pkg::SIZE_W'(MAX_ITEM_BYTES)) begin
            eff_size = brmf_pkg::SIZE_W'(MAX_ITEM_BYTES);
        end
        eff_count = (r_item_count == '0) ? brmf_pkg::COUNT_W'(1) : r_item_count;
        prod      = 9'(eff_size) * 9'(eff_count);
        total     = 10'(prod) + 10'd1;
        if (32'(total) > RING_DEPTH) begin
            ring_len = LW'(RING_DEPTH);
        end else begin
            ring_len = LW'(total);
        end
    end

    brmf_ctrl #(
        .RING_DEPTH     (RING_DEPTH),
        .MAX_ITEM_BYTES (MAX_ITEM_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (i_cfg_we),
        .i_size      (eff_size),
        .i_len       (ring_len),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    brmf_ring_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> sv/brmf_ring_mem.sv
// Byte ring storage: one write port, one read port with registered data.
`default_nettype none

module brmf_ring_mem #(
    parameter int RING_DEPTH = brmf_pkg::RING_DEPTH_DEF,
    localparam int AW        = $clog2(RING_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [7:0]    o_rdata
);

    logic [7:0] mem [RING_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/brmf_ctrl.sv
// Request sequencer: pointers, byte-serial ring access and response register.
`default_nettype none

module brmf_ctrl #(
    parameter int RING_DEPTH     = brmf_pkg::RING_DEPTH_DEF,
    parameter int MAX_ITEM_BYTES = brmf_pkg::MAX_ITEM_BYTES_DEF,
    localparam int AW            = $clog2(RING_DEPTH),
    localparam int LW            = $clog2(RING_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_clr,
    input  wire logic [brmf_pkg::SIZE_W-1:0] i_size,
    input  wire logic [LW-1:0]               i_len,
    brmf_req_if.sink                         i_req,
    brmf_rsp_if.source                       o_rsp,
    output      logic                        o_mem_we,
    output      logic [AW-1:0]               o_mem_waddr,
    output      logic [7:0]                  o_mem_wdata,
    output      logic                        o_mem_re,
    output      logic [AW-1:0]               o_mem_raddr,
    input  wire logic [7:0]                  i_mem_rdata
);

    localparam int CW = (MAX_ITEM_BYTES > 1) ? $clog2(MAX_ITEM_BYTES) : 1;
    localparam int BW = MAX_ITEM_BYTES * 8;

    brmf_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [BW-1:0]    r_data, n_data;
    logic [BW-1:0]    r_acc, n_acc;
    logic             r_rd_pend, n_rd_pend;
    logic [CW-1:0]    r_rd_lane, n_rd_lane;
    logic [1:0]       r_status, n_status;

    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_out_status;
    logic [brmf_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_full;
    logic                        r_out_empty;
    logic                        out_load;

    logic [AW-1:0] wp_inc;
    logic [AW-1:0] pos_inc;
    logic          ring_full;
    logic          ring_empty;
    logic          last_byte;

    // Advance by one byte, wrapping at the ring length.
    always_comb begin
        logic [LW-1:0] wp_nx;
        logic [LW-1:0] pos_nx;
        wp_nx   = LW'(r_wp) + LW'(1);
        pos_nx  = LW'(r_pos) + LW'(1);
        wp_inc  = (wp_nx == i_len) ? '0 : AW'(wp_nx);
        pos_inc = (pos_nx == i_len) ? '0 : AW'(pos_nx);
    end

    assign ring_full  = (wp_inc == r_rp);
    assign ring_empty = (r_wp == r_rp);
    assign last_byte  = (brmf_pkg::SIZE_W'(r_cnt) == i_size - brmf_pkg::SIZE_W'(1));

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_data      = r_data;
        n_acc       = r_acc;
        n_rd_pend   = 1'b0;
        n_rd_lane   = r_rd_lane;
        n_status    = r_status;
        out_load    = 1'b0;
        i_req.ready = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = r_data[7:0];
        o_mem_raddr = r_pos;

        // Collect the byte read in the previous cycle.
        if (r_rd_pend) begin
            for (int k = 0; k < MAX_ITEM_BYTES; k++) begin
                if (CW'(k) == r_rd_lane) begin
                    n_acc[k*8 +: 8] = i_mem_rdata;
                end
            end
        end

        unique case (r_state)
            brmf_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_data   = i_req.push_data[BW-1:0];
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_status = brmf_pkg::STATUS_OK;
                    if (i_req.action == brmf_pkg::ACT_PUSH) begin
                        if (ring_full) begin
                            n_status = brmf_pkg::STATUS_FULL;
                            n_state  = brmf_pkg::ST_FIN;
                        end else begin
                            n_pos   = r_wp;
                            n_state = brmf_pkg::ST_WRITE;
                        end
                    end else begin
                        if (ring_empty) begin
                            n_status = brmf_pkg::STATUS_EMPTY;
                            n_state  = brmf_pkg::ST_FIN;
                        end else begin
                            n_pos   = r_rp;
                            n_state = brmf_pkg::ST_READ;
                        end
                    end
                end
            end
            brmf_pkg::ST_WRITE: begin
                o_mem_we = 1'b1;
                n_data   = r_data >> 8;
                n_pos    = pos_inc;
                n_cnt    = r_cnt + CW'(1);
                if (last_byte) begin
                    n_wp    = pos_inc;
                    n_state = brmf_pkg::ST_FIN;
                end
            end
            brmf_pkg::ST_READ: begin
                o_mem_re  = 1'b1;
                n_rd_pend = 1'b1;
                n_rd_lane = r_cnt;
                n_pos     = pos_inc;
                n_cnt     = r_cnt + CW'(1);
                if (last_byte) begin
                    n_rp    = pos_inc;
                    n_state = brmf_pkg::ST_DRAIN;
                end
            end
            brmf_pkg::ST_DRAIN: begin
                n_state = brmf_pkg::ST_FIN;
            end
            brmf_pkg::ST_FIN: begin
                // hold until the response slot is free
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = brmf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = brmf_pkg::ST_IDLE;
            end
        endcase

        // A register write restarts the queue empty.
        if (i_clr) begin
            n_wp = '0;
            n_rp = '0;
        end

        n_out_valid = r_out_valid && !o_rsp.ready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brmf_pkg::ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_cnt     <= n_cnt;
        r_data    <= n_data;
        r_acc     <= n_acc;
        r_rd_lane <= n_rd_lane;
        r_status  <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_data   <= brmf_pkg::DATA_W'(r_acc);
            r_out_full   <= ring_full;
            r_out_empty  <= ring_empty;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.pop_data  = r_out_data;
    assign o_rsp.now_full  = r_out_full;
    assign o_rsp.now_empty = r_out_empty;

endmodule

`default_nettype wire

>>> sv/brmf_checker.sv
// Port-level assertions for the byte ring message FIFO, bound to the top level.
`default_nettype none

module brmf_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic [1:0]                  i_rsp_status,
    input wire logic [brmf_pkg::DATA_W-1:0] i_rsp_pop_data,
    input wire logic                        i_rsp_now_full,
    input wire logic                        i_rsp_now_empty
);

    // The ring is at least two bytes long, so it cannot be full and empty.
    a_full_empty_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_now_full && i_rsp_now_empty))
        else $error("response shows full and empty together");

    a_refused_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == brmf_pkg::STATUS_FULL) |-> i_rsp_now_full)
        else $error("refused push while ring not full");

    a_refused_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == brmf_pkg::STATUS_EMPTY) |-> i_rsp_now_empty)
        else $error("refused pop while ring not empty");

    a_refused_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != brmf_pkg::STATUS_OK) |-> (i_rsp_pop_data == '0))
        else $error("refused request carries data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_pop_data)
                                          && $stable(i_rsp_status)))
        else $error("stalled response changed");

endmodule

bind byte_ring_message_fifo_top brmf_checker u_brmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_pop_data  (o_rsp.pop_data),
    .i_rsp_now_full  (o_rsp.now_full),
    .i_rsp_now_empty (o_rsp.now_empty)
);

`default_nettype wire
